// File: rtl/clamp_point_to_polygon_assert.svh
`ifndef CLAMP_POINT_TO_POLYGON_ASSERT_SVH
`define CLAMP_POINT_TO_POLYGON_ASSERT_SVH

// check that holds in the same cycle as its trigger
`define CPP_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle port check failed");

// check that holds in the cycle after its trigger
`define CPP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle port check failed");

`endif

// File: rtl/cpp_pkg.sv
package cpp_pkg;

  // coordinate and intermediate widths
  localparam int CW       = 32;       // signed coordinate
  localparam int DW       = CW + 1;   // coordinate difference
  localparam int PW       = 2 * DW;   // product of two differences
  localparam int SW       = PW + 1;   // sum of two products
  localparam int LW       = PW;       // squared edge length, unsigned
  localparam int NW       = 99;       // rounding dividend
  localparam int QW       = 34;       // quotient bits, one per divider stage
  localparam int VREG_W   = 64;       // vertex register
  localparam int CFG_IW   = 4;        // register index
  localparam int EDGE_LAT = 6;        // stages in the edge front end

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  // where the nearest foot on an edge lies
  typedef enum logic [1:0] {
    CLS_A,   // at the start vertex
    CLS_B,   // at the end vertex
    CLS_M    // strictly between, needs the rounded projection
  } cls_t;

  // per-edge flags carried alongside the divider
  typedef struct packed {
    logic on_edge;
    logic wind_up;
    logic wind_dn;
    logic skip;
    cls_t cls;
    logic neg_x;
    logic neg_y;
  } etag_t;

endpackage

// File: rtl/clamp_point_to_polygon.sv
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+-------------------------------------
// in_       | request   | in_valid / in_ready     | in_point_x, in_point_y
// out_      | result    | out_valid / out_ready   | out_clamped_x, out_clamped_y,
//           |           |                         | out_was_inside
// cfg_      | write     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one request per cycle while in_ready is high; a result passes the edge front end, the
// 34-stage rounding divider and the selection stages
// synchronous active-low reset clears the vertices and all valid bits
// an output register plus one skid entry: in_ready drops only once a stalled
// result and one more are both held, and no request is lost or repeated
// cfg_ready is always high; a write beyond the vertex list is dropped
module clamp_point_to_polygon #(
  parameter int NUM_VERTICES = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cpp_pkg::coord_t             in_point_x,
  input  cpp_pkg::coord_t             in_point_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cpp_pkg::coord_t             out_clamped_x,
  output cpp_pkg::coord_t             out_clamped_y,
  output logic                        out_was_inside,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cpp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [cpp_pkg::VREG_W-1:0]  cfg_data
);
  import cpp_pkg::*;

  localparam int LV  = $clog2(NUM_VERTICES);
  localparam int PL  = EDGE_LAT + QW;
  localparam int LAT = PL + LV + 4;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   ins;
  } res_t;

  coord_t vx_r [NUM_VERTICES];
  coord_t vy_r [NUM_VERTICES];
  coord_t ptx_r [PL];
  coord_t pty_r [PL];
  logic [LAT-1:0] vld_r;
  logic   en;
  logic   out_vld_r, skid_vld_r;
  res_t   out_r, skid_r, res_c;

  logic [NW-1:0]  num_x [NUM_VERTICES];
  logic [NW-1:0]  num_y [NUM_VERTICES];
  logic [LW:0]    den   [NUM_VERTICES];
  etag_t          etag  [NUM_VERTICES];
  logic [QW-1:0]  quo_x [NUM_VERTICES];
  logic [QW-1:0]  quo_y [NUM_VERTICES];
  etag_t          dtag  [NUM_VERTICES];

  // vertex registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NUM_VERTICES; v++) begin
        vx_r[v] <= '0;
        vy_r[v] <= '0;
      end
    end else begin
      for (int v = 0; v < NUM_VERTICES; v++) begin
        if (cfg_valid && cfg_index == CFG_IW'(v)) begin
          vx_r[v] <= cfg_data[CW-1:0];
          vy_r[v] <= cfg_data[VREG_W-1:CW];
        end
      end
    end
  end

  assign cfg_ready = 1'b1;

  // pipeline advances whenever the skid entry is free
  assign en       = !skid_vld_r;
  assign in_ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // point delay line up to the selection stages
  always_ff @(posedge clk) begin
    if (en) begin
      ptx_r[0] <= in_point_x;
      pty_r[0] <= in_point_y;
      for (int k = 1; k < PL; k++) begin
        ptx_r[k] <= ptx_r[k-1];
        pty_r[k] <= pty_r[k-1];
      end
    end
  end

  // per-edge front end and rounding divider
  for (genvar e = 0; e < NUM_VERTICES; e++) begin : g_edge
    localparam int NB = (e + 1) % NUM_VERTICES;

    cpp_edge u_edge (
      .clk   (clk),
      .en    (en),
      .px    (in_point_x),
      .py    (in_point_y),
      .ax    (vx_r[e]),
      .ay    (vy_r[e]),
      .bx    (vx_r[NB]),
      .by    (vy_r[NB]),
      .num_x (num_x[e]),
      .num_y (num_y[e]),
      .den   (den[e]),
      .tag   (etag[e])
    );

    cpp_rdiv u_rdiv (
      .clk     (clk),
      .en      (en),
      .num_x   (num_x[e]),
      .num_y   (num_y[e]),
      .den     (den[e]),
      .tag_in  (etag[e]),
      .quo_x   (quo_x[e]),
      .quo_y   (quo_y[e]),
      .tag_out (dtag[e])
    );
  end

  // nearest foot and inside decision
  cpp_pick #(
    .NV (NUM_VERTICES)
  ) u_pick (
    .clk    (clk),
    .en     (en),
    .px     (ptx_r[PL-1]),
    .py     (pty_r[PL-1]),
    .vx     (vx_r),
    .vy     (vy_r),
    .quo_x  (quo_x),
    .quo_y  (quo_y),
    .tag    (dtag),
    .res_x  (res_c.x),
    .res_y  (res_c.y),
    .res_in (res_c.ins)
  );

  // output register and skid entry, control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_ready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= vld_r[LAT-1];
      end
    end else if (vld_r[LAT-1] && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output register and skid entry, payload
  always_ff @(posedge clk) begin
    if (out_ready || !out_vld_r) begin
      out_r <= skid_vld_r ? skid_r : res_c;
    end else if (!skid_vld_r) begin
      skid_r <= res_c;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_clamped_x  = out_r.x;
  assign out_clamped_y  = out_r.y;
  assign out_was_inside = out_r.ins;

endmodule

// File: rtl/cpp_edge.sv
module cpp_edge (
  input  logic                    clk,
  input  logic                    en,
  input  cpp_pkg::coord_t         px,
  input  cpp_pkg::coord_t         py,
  input  cpp_pkg::coord_t         ax,
  input  cpp_pkg::coord_t         ay,
  input  cpp_pkg::coord_t         bx,
  input  cpp_pkg::coord_t         by,
  output logic [cpp_pkg::NW-1:0]  num_x,
  output logic [cpp_pkg::NW-1:0]  num_y,
  output logic [cpp_pkg::LW:0]    den,
  output cpp_pkg::etag_t          tag
);
  import cpp_pkg::*;

  localparam int DLW = LW - 1;  // clamped dot product, positive

  // stage 1
  diff_t ex_r, ey_r, wx_r, wy_r;
  logic  box_r, ale_r, bgt_r;
  // stage 2
  logic signed [PW-1:0] c1_r, c2_r, l1_r, l2_r, d1_r, d2_r;
  diff_t ex2_r, ey2_r;
  logic  box2_r, ale2_r, bgt2_r, skip2_r;
  // stage 3
  logic signed [SW-1:0] cross_r, dot_r;
  logic [LW-1:0] len2_r;
  diff_t ex3_r, ey3_r;
  logic  box3_r, ale3_r, bgt3_r, skip3_r;
  // stage 4
  logic signed [SW-1:0] pxl_r, pyl_r;
  logic signed [PW-1:0] pxh_r, pyh_r;
  logic [LW-1:0] len2_4_r;
  logic on4_r, up4_r, dn4_r, skip4_r;
  cls_t cls4_r;
  // stage 5
  logic [NW-2:0] mag_x_r, mag_y_r;
  logic neg_x_r, neg_y_r;
  logic [LW-1:0] len2_5_r;
  logic on5_r, up5_r, dn5_r, skip5_r;
  cls_t cls5_r;
  // stage 6
  logic [NW-1:0] num_x_r, num_y_r;
  logic [LW:0] den_r;
  etag_t tag_r;

  // stage 1: edge and offset vectors, bounding box and crossing tests
  always_ff @(posedge clk) begin
    if (en) begin
      ex_r  <= diff_t'(bx) - diff_t'(ax);
      ey_r  <= diff_t'(by) - diff_t'(ay);
      wx_r  <= diff_t'(px) - diff_t'(ax);
      wy_r  <= diff_t'(py) - diff_t'(ay);
      box_r <= ((px >= ax && px <= bx) || (px >= bx && px <= ax)) &&
               ((py >= ay && py <= by) || (py >= by && py <= ay));
      ale_r <= ay <= py;
      bgt_r <= by > py;
    end
  end

  // stage 2: the six products
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= ex_r * wy_r;
      c2_r    <= wx_r * ey_r;
      l1_r    <= ex_r * ex_r;
      l2_r    <= ey_r * ey_r;
      d1_r    <= wx_r * ex_r;
      d2_r    <= wy_r * ey_r;
      ex2_r   <= ex_r;
      ey2_r   <= ey_r;
      box2_r  <= box_r;
      ale2_r  <= ale_r;
      bgt2_r  <= bgt_r;
      skip2_r <= (ex_r == '0) && (ey_r == '0);
    end
  end

  // stage 3: cross product, squared length, dot product
  always_ff @(posedge clk) begin
    if (en) begin
      cross_r <= SW'(c1_r) - SW'(c2_r);
      len2_r  <= $unsigned(l1_r) + $unsigned(l2_r);
      dot_r   <= SW'(d1_r) + SW'(d2_r);
      ex3_r   <= ex2_r;
      ey3_r   <= ey2_r;
      box3_r  <= box2_r;
      ale3_r  <= ale2_r;
      bgt3_r  <= bgt2_r;
      skip3_r <= skip2_r;
    end
  end

  // stage 4: winding flags, projection class, partial numerators
  logic       cr_neg, cr_zero;
  cls_t       cls_c;
  logic [DLW-1:0] dcl;
  logic [DW-1:0]  dlo;
  logic [DLW-DW-1:0] dhi;

  always_comb begin
    cr_neg  = cross_r[SW-1];
    cr_zero = cross_r == '0;
    if (dot_r[SW-1] || dot_r == '0) begin
      cls_c = CLS_A;
    end else if ($unsigned(dot_r) >= {1'b0, len2_r}) begin
      cls_c = CLS_B;
    end else begin
      cls_c = CLS_M;
    end
    dcl = (cls_c == CLS_M) ? dot_r[DLW-1:0] : '0;
    dlo = dcl[DW-1:0];
    dhi = dcl[DLW-1:DW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl_r    <= ex3_r * $signed({1'b0, dlo});
      pyl_r    <= ey3_r * $signed({1'b0, dlo});
      pxh_r    <= ex3_r * $signed({1'b0, dhi});
      pyh_r    <= ey3_r * $signed({1'b0, dhi});
      len2_4_r <= len2_r;
      on4_r    <= cr_zero && box3_r;
      up4_r    <= ale3_r && bgt3_r && !cr_neg && !cr_zero;
      dn4_r    <= !ale3_r && !bgt3_r && cr_neg;
      skip4_r  <= skip3_r;
      cls4_r   <= cls_c;
    end
  end

  // stage 5: full numerators, split into sign and magnitude
  logic signed [NW-1:0] nx_c, ny_c, mx_c, my_c;

  always_comb begin
    nx_c = (NW'(pxh_r) <<< DW) + NW'(pxl_r);
    ny_c = (NW'(pyh_r) <<< DW) + NW'(pyl_r);
    mx_c = nx_c[NW-1] ? -nx_c : nx_c;
    my_c = ny_c[NW-1] ? -ny_c : ny_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_x_r  <= mx_c[NW-2:0];
      mag_y_r  <= my_c[NW-2:0];
      neg_x_r  <= nx_c[NW-1];
      neg_y_r  <= ny_c[NW-1];
      len2_5_r <= len2_4_r;
      on5_r    <= on4_r;
      up5_r    <= up4_r;
      dn5_r    <= dn4_r;
      skip5_r  <= skip4_r;
      cls5_r   <= cls4_r;
    end
  end

  // stage 6: round to nearest as (2*mag + len2) / (2*len2)
  always_ff @(posedge clk) begin
    if (en) begin
      num_x_r <= {mag_x_r, 1'b0} + NW'(len2_5_r);
      num_y_r <= {mag_y_r, 1'b0} + NW'(len2_5_r);
      den_r   <= {len2_5_r, 1'b0};
      tag_r   <= '{on_edge: on5_r, wind_up: up5_r, wind_dn: dn5_r, skip: skip5_r,
                   cls: cls5_r, neg_x: neg_x_r, neg_y: neg_y_r};
    end
  end

  assign num_x = num_x_r;
  assign num_y = num_y_r;
  assign den   = den_r;
  assign tag   = tag_r;

endmodule

// File: rtl/cpp_rdiv.sv
module cpp_rdiv (
  input  logic                    clk,
  input  logic                    en,
  input  logic [cpp_pkg::NW-1:0]  num_x,
  input  logic [cpp_pkg::NW-1:0]  num_y,
  input  logic [cpp_pkg::LW:0]    den,
  input  cpp_pkg::etag_t          tag_in,
  output logic [cpp_pkg::QW-1:0]  quo_x,
  output logic [cpp_pkg::QW-1:0]  quo_y,
  output cpp_pkg::etag_t          tag_out
);
  import cpp_pkg::*;

  localparam int TW = LW + 1 + QW;  // room for the divisor at its top shift

  logic [NW-1:0] rx_r [QW];
  logic [NW-1:0] ry_r [QW];
  logic [QW-1:0] qx_r [QW];
  logic [QW-1:0] qy_r [QW];
  logic [LW:0]   dv_r [QW];
  etag_t         tg_r [QW];

  // one quotient bit per stage, most significant first, shared divisor
  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int K = QW - 1 - s;
    logic [NW-1:0] rx_in, ry_in;
    logic [QW-1:0] qx_in, qy_in;
    logic [LW:0]   dv_in;
    etag_t         tg_in;
    logic [TW-1:0] dsh;
    logic          gx, gy;

    if (s == 0) begin : g_first
      assign rx_in = num_x;
      assign ry_in = num_y;
      assign qx_in = '0;
      assign qy_in = '0;
      assign dv_in = den;
      assign tg_in = tag_in;
    end else begin : g_next
      assign rx_in = rx_r[s-1];
      assign ry_in = ry_r[s-1];
      assign qx_in = qx_r[s-1];
      assign qy_in = qy_r[s-1];
      assign dv_in = dv_r[s-1];
      assign tg_in = tg_r[s-1];
    end

    always_comb begin
      dsh = TW'(dv_in) << K;
      gx  = TW'(rx_in) >= dsh;
      gy  = TW'(ry_in) >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[s] <= gx ? NW'(TW'(rx_in) - dsh) : rx_in;
        ry_r[s] <= gy ? NW'(TW'(ry_in) - dsh) : ry_in;
        qx_r[s] <= qx_in | (QW'(gx) << K);
        qy_r[s] <= qy_in | (QW'(gy) << K);
        dv_r[s] <= dv_in;
        tg_r[s] <= tg_in;
      end
    end
  end

  assign quo_x   = qx_r[QW-1];
  assign quo_y   = qy_r[QW-1];
  assign tag_out = tg_r[QW-1];

endmodule

// File: rtl/cpp_pick.sv
module cpp_pick #(
  parameter int NV = 6
) (
  input  logic                    clk,
  input  logic                    en,
  input  cpp_pkg::coord_t         px,
  input  cpp_pkg::coord_t         py,
  input  cpp_pkg::coord_t         vx    [NV],
  input  cpp_pkg::coord_t         vy    [NV],
  input  logic [cpp_pkg::QW-1:0]  quo_x [NV],
  input  logic [cpp_pkg::QW-1:0]  quo_y [NV],
  input  cpp_pkg::etag_t          tag   [NV],
  output cpp_pkg::coord_t         res_x,
  output cpp_pkg::coord_t         res_y,
  output logic                    res_in
);
  import cpp_pkg::*;

  localparam int LV  = $clog2(NV);
  localparam int TN  = 1 << LV;
  localparam int WSW = $clog2(NV + 1) + 1;

  typedef struct packed {
    logic          found;
    logic [LW-1:0] dsq;
    coord_t        x;
    coord_t        y;
  } cand_t;

  typedef struct packed {
    logic   ins;
    coord_t x;
    coord_t y;
  } carry_t;

  diff_t  dx_r [NV];
  diff_t  dy_r [NV];
  coord_t fx_r [NV];
  coord_t fy_r [NV];
  logic   use_r [NV];
  logic signed [PW-1:0] sqx_r [NV];
  logic signed [PW-1:0] sqy_r [NV];
  coord_t fx2_r [NV];
  coord_t fy2_r [NV];
  logic   use2_r [NV];
  cand_t  tree_r [LV+1][TN];
  carry_t car_r [LV+3];
  coord_t res_x_r, res_y_r;
  logic   res_in_r;

  // inside test: on any edge, or nonzero winding
  logic signed [WSW-1:0] wsum;
  logic on_any;

  always_comb begin
    wsum   = '0;
    on_any = 1'b0;
    for (int e = 0; e < NV; e++) begin
      on_any = on_any | tag[e].on_edge;
      if (tag[e].wind_up) wsum = wsum + WSW'(1);
      if (tag[e].wind_dn) wsum = wsum - WSW'(1);
    end
  end

  // foot on each edge and its offset from the point
  for (genvar e = 0; e < NV; e++) begin : g_foot
    localparam int NB = (e + 1) % NV;
    coord_t fx_c, fy_c;

    always_comb begin
      case (tag[e].cls)
        CLS_A: begin
          fx_c = vx[e];
          fy_c = vy[e];
        end
        CLS_B: begin
          fx_c = vx[NB];
          fy_c = vy[NB];
        end
        CLS_M: begin
          fx_c = tag[e].neg_x ? vx[e] - $signed(quo_x[e][CW-1:0])
                              : vx[e] + $signed(quo_x[e][CW-1:0]);
          fy_c = tag[e].neg_y ? vy[e] - $signed(quo_y[e][CW-1:0])
                              : vy[e] + $signed(quo_y[e][CW-1:0]);
        end
        default: begin
          fx_c = vx[e];
          fy_c = vy[e];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dx_r[e]  <= diff_t'(px) - diff_t'(fx_c);
        dy_r[e]  <= diff_t'(py) - diff_t'(fy_c);
        fx_r[e]  <= fx_c;
        fy_r[e]  <= fy_c;
        use_r[e] <= !tag[e].skip;
      end
    end

    // squared offsets
    always_ff @(posedge clk) begin
      if (en) begin
        sqx_r[e]  <= dx_r[e] * dx_r[e];
        sqy_r[e]  <= dy_r[e] * dy_r[e];
        fx2_r[e]  <= fx_r[e];
        fy2_r[e]  <= fy_r[e];
        use2_r[e] <= use_r[e];
      end
    end
  end

  // leaves: squared distance per edge, padding leaves never win
  for (genvar i = 0; i < TN; i++) begin : g_leaf
    if (i < NV) begin : g_real
      always_ff @(posedge clk) begin
        if (en) begin
          tree_r[0][i] <= '{found: use2_r[i],
                            dsq:   $unsigned(sqx_r[i]) + $unsigned(sqy_r[i]),
                            x:     fx2_r[i],
                            y:     fy2_r[i]};
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          tree_r[0][i] <= '0;
        end
      end
    end
  end

  // minimum tree, the lower edge keeps ties
  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    for (genvar i = 0; i < TN; i++) begin : g_node
      if (i < (TN >> l)) begin : g_cmp
        cand_t lc, rc;
        assign lc = tree_r[l-1][2*i];
        assign rc = tree_r[l-1][2*i+1];
        always_ff @(posedge clk) begin
          if (en) begin
            tree_r[l][i] <= (rc.found && (!lc.found || rc.dsq < lc.dsq)) ? rc : lc;
          end
        end
      end else begin : g_idle
        always_ff @(posedge clk) begin
          if (en) begin
            tree_r[l][i] <= '0;
          end
        end
      end
    end
  end

  // point and inside flag ride along with the tree
  always_ff @(posedge clk) begin
    if (en) begin
      car_r[0] <= '{ins: on_any || (wsum != '0), x: px, y: py};
      for (int k = 1; k < LV + 3; k++) begin
        car_r[k] <= car_r[k-1];
      end
    end
  end

  // final choice: inside or no usable edge keeps the point
  always_ff @(posedge clk) begin
    if (en) begin
      res_in_r <= car_r[LV+2].ins;
      if (car_r[LV+2].ins || !tree_r[LV][0].found) begin
        res_x_r <= car_r[LV+2].x;
        res_y_r <= car_r[LV+2].y;
      end else begin
        res_x_r <= tree_r[LV][0].x;
        res_y_r <= tree_r[LV][0].y;
      end
    end
  end

  assign res_x  = res_x_r;
  assign res_y  = res_y_r;
  assign res_in = res_in_r;

endmodule

// File: rtl/cpp_checker.sv
`include "clamp_point_to_polygon_assert.svh"

module cpp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input cpp_pkg::coord_t             in_point_x,
  input cpp_pkg::coord_t             in_point_y,
  input logic                        out_valid,
  input logic                        out_ready,
  input cpp_pkg::coord_t             out_clamped_x,
  input cpp_pkg::coord_t             out_clamped_y,
  input logic                        out_was_inside,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [cpp_pkg::CFG_IW-1:0]  cfg_index,
  input logic [cpp_pkg::VREG_W-1:0]  cfg_data
);

  // a stalled result holds
  `CPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_clamped_x) && $stable(out_clamped_y) &&
                   $stable(out_was_inside))

  // backpressure reaches the input only after a result was refused
  `CPP_ASSERT_SAME(a_ready_falls_on_stall, $fell(in_ready), $past(out_valid && !out_ready))

  // while requests are refused a result is on offer
  `CPP_ASSERT_SAME(a_blocked_has_result, !in_ready, out_valid)

  // reset empties the output side
  `CPP_ASSERT_SAME(a_reset_empty, $past(!rst_n), !out_valid && in_ready)

endmodule

bind clamp_point_to_polygon cpp_checker u_cpp_checker (.*);
